// File: rtl/dll_pkg.sv
package dll_pkg;

   localparam int CAPACITY   = 256;
   localparam int VALUE_BITS = 32;
   localparam int IDX_BITS   = $clog2(CAPACITY);
   localparam int LINK_BITS  = $clog2(CAPACITY + 1);

   localparam logic [LINK_BITS-1:0] NIL_LINK  = LINK_BITS'(CAPACITY);
   localparam logic [LINK_BITS-1:0] FULL_FREE = LINK_BITS'(CAPACITY);

   typedef enum logic [2:0] {
      ACT_INS_FRONT = 3'd0,
      ACT_INS_BACK  = 3'd1,
      ACT_INS_POS   = 3'd2,
      ACT_DEL_FRONT = 3'd3,
      ACT_DEL_BACK  = 3'd4,
      ACT_DEL_VALUE = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_EMPTY   = 3'd1,
      STAT_MISS    = 3'd2,
      STAT_BAD_POS = 3'd3,
      STAT_FULL    = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      FSM_IDLE,
      FSM_DECIDE,
      FSM_ALLOC,
      FSM_WALK,
      FSM_LINK1,
      FSM_LINK2,
      FSM_FRONT1,
      FSM_FRONT2,
      FSM_SEARCH,
      FSM_UNLINK,
      FSM_DONE
   } fsm_state_type;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [31:0] item_value;
      logic [11:0]        position;
   } req_word_type;

   typedef struct packed {
      logic [2:0]           status;
      logic signed [31:0]   removed_value;
      logic [LINK_BITS-1:0] list_length;
   } rsp_word_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   node_raddr;
      logic                  val_we;
      logic [IDX_BITS-1:0]   val_waddr;
      logic [VALUE_BITS-1:0] val_wdata;
      logic                  nxt_we;
      logic [IDX_BITS-1:0]   nxt_waddr;
      logic [LINK_BITS-1:0]  nxt_wdata;
      logic                  prv_we;
      logic [IDX_BITS-1:0]   prv_waddr;
      logic [LINK_BITS-1:0]  prv_wdata;
      logic [IDX_BITS-1:0]   fre_raddr;
      logic                  fre_we;
      logic [IDX_BITS-1:0]   fre_waddr;
      logic [IDX_BITS-1:0]   fre_wdata;
   } mem_req_type;

   typedef struct packed {
      logic [VALUE_BITS-1:0] val_rdata;
      logic [LINK_BITS-1:0]  nxt_rdata;
      logic [LINK_BITS-1:0]  prv_rdata;
      logic [IDX_BITS-1:0]   fre_rdata;
   } mem_rsp_type;

   // sign-extend the 32-bit input and cut it to the stored width
   function automatic logic [VALUE_BITS-1:0] cut_value(logic signed [31:0] v);
      logic signed [63:0] w;
      w = 64'(v);
      return w[VALUE_BITS-1:0];
   endfunction

   // sign-extend a stored value and cut it to 32 bits
   function automatic logic [31:0] widen_value(logic [VALUE_BITS-1:0] v);
      logic signed [63:0] w;
      w = 64'(signed'(v));
      return w[31:0];
   endfunction

endpackage

// File: rtl/dll_ram.sv
module dll_ram #(
   parameter int WIDTH     = 32,
   parameter int ADDR_BITS = 8
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [2**ADDR_BITS];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/dll_ctrl.sv
module dll_ctrl import dll_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  req_word_type req_word,
   output logic         idle,
   output logic         done,
   output rsp_word_type result,
   output mem_req_type  mem_req,
   input  mem_rsp_type  mem_rsp
);

   fsm_state_type         state_ff, state_in;
   action_type            act_ff;
   logic [VALUE_BITS-1:0] val_ff;
   logic [11:0]           pos_ff;
   logic [LINK_BITS-1:0]  head_ff, tail_ff;
   logic [LINK_BITS-1:0]  count_ff, free_ff, minfree_ff;
   logic [IDX_BITS-1:0]   n_ff, cur_ff;
   logic [LINK_BITS-1:0]  p_ff, q_ff;
   logic [LINK_BITS-1:0]  hops_ff;
   status_type            status_ff;
   logic [31:0]           removed_ff;

   logic [LINK_BITS-1:0]  top_slot;
   logic [IDX_BITS-1:0]   new_node;
   logic                  match;
   logic                  front_ins;
   logic                  pos_over;
   status_type            decide_status;

   assign top_slot  = free_ff - LINK_BITS'(1);
   // slots below the low-water mark were never pushed and still hold their own index
   assign new_node  = (top_slot < minfree_ff) ? top_slot[IDX_BITS-1:0] : mem_rsp.fre_rdata;
   assign match     = (act_ff != ACT_DEL_VALUE) || (mem_rsp.val_rdata == val_ff);
   assign front_ins = (act_ff == ACT_INS_FRONT)
                   || ((act_ff == ACT_INS_BACK) && (tail_ff == NIL_LINK))
                   || ((act_ff == ACT_INS_POS) && (pos_ff == 12'd1));
   assign pos_over  = 32'(pos_ff) > (32'(count_ff) + 32'd1);

   always_comb begin
      decide_status = STAT_OK;
      case (act_ff)
         ACT_INS_FRONT, ACT_INS_BACK: begin
            if (free_ff == '0) begin
               decide_status = STAT_FULL;
            end
         end
         ACT_INS_POS: begin
            if (pos_ff == '0) begin
               decide_status = STAT_BAD_POS;
            end else if (free_ff == '0) begin
               decide_status = STAT_FULL;
            end else if (pos_over) begin
               decide_status = STAT_MISS;
            end
         end
         ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_VALUE: begin
            if (head_ff == NIL_LINK) begin
               decide_status = STAT_EMPTY;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               state_in = FSM_DECIDE;
            end
         end
         FSM_DECIDE: begin
            case (act_ff)
               ACT_INS_FRONT, ACT_INS_BACK: begin
                  state_in = (free_ff == '0) ? FSM_DONE : FSM_ALLOC;
               end
               ACT_INS_POS: begin
                  state_in = ((pos_ff == '0) || (free_ff == '0) || pos_over)
                           ? FSM_DONE : FSM_ALLOC;
               end
               ACT_DEL_FRONT, ACT_DEL_BACK, ACT_DEL_VALUE: begin
                  state_in = (head_ff == NIL_LINK) ? FSM_DONE : FSM_SEARCH;
               end
               default: begin
                  state_in = FSM_DONE;
               end
            endcase
         end
         FSM_ALLOC: begin
            if (front_ins) begin
               state_in = FSM_FRONT1;
            end else if (act_ff == ACT_INS_BACK) begin
               state_in = FSM_LINK1;
            end else begin
               state_in = FSM_WALK;
            end
         end
         FSM_WALK: begin
            if (hops_ff == '0) begin
               state_in = FSM_LINK1;
            end
         end
         FSM_LINK1:  state_in = FSM_LINK2;
         FSM_LINK2:  state_in = FSM_DONE;
         FSM_FRONT1: state_in = FSM_FRONT2;
         FSM_FRONT2: state_in = FSM_DONE;
         FSM_SEARCH: begin
            if (match) begin
               state_in = FSM_UNLINK;
            end else if (mem_rsp.nxt_rdata == NIL_LINK) begin
               state_in = FSM_DONE;
            end
         end
         FSM_UNLINK: state_in = FSM_DONE;
         FSM_DONE:   state_in = FSM_IDLE;
         default:    state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      mem_req            = '0;
      mem_req.node_raddr = cur_ff;
      mem_req.fre_raddr  = top_slot[IDX_BITS-1:0];
      mem_req.val_wdata  = val_ff;
      idle               = (state_ff == FSM_IDLE);
      done               = (state_ff == FSM_DONE);
      case (state_ff)
         FSM_DECIDE: begin
            mem_req.node_raddr = (act_ff == ACT_DEL_BACK) ? tail_ff[IDX_BITS-1:0]
                                                          : head_ff[IDX_BITS-1:0];
         end
         FSM_ALLOC: begin
            mem_req.node_raddr = head_ff[IDX_BITS-1:0];
         end
         FSM_WALK, FSM_SEARCH: begin
            // follow the link just read
            mem_req.node_raddr = mem_rsp.nxt_rdata[IDX_BITS-1:0];
         end
         FSM_LINK1: begin
            mem_req.val_we    = 1'b1;
            mem_req.val_waddr = n_ff;
            mem_req.nxt_we    = 1'b1;
            mem_req.nxt_waddr = n_ff;
            mem_req.nxt_wdata = q_ff;
            mem_req.prv_we    = 1'b1;
            mem_req.prv_waddr = n_ff;
            mem_req.prv_wdata = p_ff;
         end
         FSM_LINK2: begin
            mem_req.nxt_we    = 1'b1;
            mem_req.nxt_waddr = p_ff[IDX_BITS-1:0];
            mem_req.nxt_wdata = LINK_BITS'(n_ff);
            mem_req.prv_we    = (q_ff != NIL_LINK);
            mem_req.prv_waddr = q_ff[IDX_BITS-1:0];
            mem_req.prv_wdata = LINK_BITS'(n_ff);
         end
         FSM_FRONT1: begin
            mem_req.val_we    = 1'b1;
            mem_req.val_waddr = n_ff;
            mem_req.nxt_we    = 1'b1;
            mem_req.nxt_waddr = n_ff;
            mem_req.nxt_wdata = head_ff;
            mem_req.prv_we    = 1'b1;
            mem_req.prv_waddr = n_ff;
            mem_req.prv_wdata = NIL_LINK;
         end
         FSM_FRONT2: begin
            mem_req.prv_we    = (head_ff != NIL_LINK);
            mem_req.prv_waddr = head_ff[IDX_BITS-1:0];
            mem_req.prv_wdata = LINK_BITS'(n_ff);
         end
         FSM_UNLINK: begin
            mem_req.nxt_we    = (p_ff != NIL_LINK);
            mem_req.nxt_waddr = p_ff[IDX_BITS-1:0];
            mem_req.nxt_wdata = q_ff;
            mem_req.prv_we    = (q_ff != NIL_LINK);
            mem_req.prv_waddr = q_ff[IDX_BITS-1:0];
            mem_req.prv_wdata = p_ff;
            mem_req.fre_we    = (free_ff != FULL_FREE);
            mem_req.fre_waddr = free_ff[IDX_BITS-1:0];
            mem_req.fre_wdata = cur_ff;
         end
         default: begin
         end
      endcase
   end

   assign result.status        = status_ff;
   assign result.removed_value = removed_ff;
   assign result.list_length   = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= FSM_IDLE;
         head_ff    <= NIL_LINK;
         tail_ff    <= NIL_LINK;
         count_ff   <= '0;
         free_ff    <= FULL_FREE;
         minfree_ff <= FULL_FREE;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            FSM_ALLOC: begin
               free_ff  <= top_slot;
               count_ff <= count_ff + LINK_BITS'(1);
               if (top_slot < minfree_ff) begin
                  minfree_ff <= top_slot;
               end
            end
            FSM_LINK2: begin
               if (q_ff == NIL_LINK) begin
                  tail_ff <= LINK_BITS'(n_ff);
               end
            end
            FSM_FRONT2: begin
               if (head_ff == NIL_LINK) begin
                  tail_ff <= LINK_BITS'(n_ff);
               end
               head_ff <= LINK_BITS'(n_ff);
            end
            FSM_UNLINK: begin
               if (p_ff == NIL_LINK) begin
                  head_ff <= q_ff;
               end
               if (q_ff == NIL_LINK) begin
                  tail_ff <= p_ff;
               end
               if (free_ff != FULL_FREE) begin
                  free_ff <= free_ff + LINK_BITS'(1);
               end
               count_ff <= count_ff - LINK_BITS'(1);
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         FSM_IDLE: begin
            if (start) begin
               act_ff <= action_type'(req_word.action);
               val_ff <= cut_value(req_word.item_value);
               pos_ff <= req_word.position;
            end
         end
         FSM_DECIDE: begin
            status_ff  <= decide_status;
            removed_ff <= '0;
            cur_ff     <= (act_ff == ACT_DEL_BACK) ? tail_ff[IDX_BITS-1:0]
                                                   : head_ff[IDX_BITS-1:0];
         end
         FSM_ALLOC: begin
            n_ff    <= new_node;
            cur_ff  <= head_ff[IDX_BITS-1:0];
            hops_ff <= LINK_BITS'(pos_ff) - LINK_BITS'(2);
            p_ff    <= tail_ff;
            q_ff    <= NIL_LINK;
         end
         FSM_WALK: begin
            if (hops_ff == '0) begin
               p_ff <= LINK_BITS'(cur_ff);
               q_ff <= mem_rsp.nxt_rdata;
            end else begin
               cur_ff  <= mem_rsp.nxt_rdata[IDX_BITS-1:0];
               hops_ff <= hops_ff - LINK_BITS'(1);
            end
         end
         FSM_SEARCH: begin
            if (match) begin
               p_ff       <= mem_rsp.prv_rdata;
               q_ff       <= mem_rsp.nxt_rdata;
               removed_ff <= widen_value(mem_rsp.val_rdata);
            end else if (mem_rsp.nxt_rdata == NIL_LINK) begin
               status_ff <= STAT_MISS;
            end else begin
               cur_ff <= mem_rsp.nxt_rdata[IDX_BITS-1:0];
            end
         end
         default: begin
         end
      endcase
   end

endmodule

// File: rtl/bounded_doubly_linked_list.sv
// Ordered list of up to 256 signed values, kept as nodes in value, next-link and
// prev-link memories with head and tail registers and a stack of free nodes. One
// request word is taken at a time and gives exactly one response word. Insert at
// position P above 1 walks from the front to the node before P, and delete by value
// walks from the front to the first match, or to the end of the list when nothing
// matches: both walk the link memory one node per cycle through its registered
// read port. No new request is taken while one is in progress or while an
// earlier response is still stalled. No clearing pass is needed after reset.
module bounded_doubly_linked_list import dll_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   logic         ctrl_idle;
   logic         ctrl_done;
   rsp_word_type ctrl_result;
   mem_req_type  mem_req;
   mem_rsp_type  mem_rsp;
   logic         start;
   logic         rsp_open;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   assign rsp_open  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !(ctrl_idle && rsp_open);
   assign start     = req_valid && !req_stall;

   dll_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_word (req_word),
      .idle     (ctrl_idle),
      .done     (ctrl_done),
      .result   (ctrl_result),
      .mem_req  (mem_req),
      .mem_rsp  (mem_rsp)
   );

   dll_ram #(.WIDTH(VALUE_BITS), .ADDR_BITS(IDX_BITS)) u_value_ram (
      .clock (clock),
      .we    (mem_req.val_we),
      .waddr (mem_req.val_waddr),
      .wdata (mem_req.val_wdata),
      .raddr (mem_req.node_raddr),
      .rdata (mem_rsp.val_rdata)
   );

   dll_ram #(.WIDTH(LINK_BITS), .ADDR_BITS(IDX_BITS)) u_next_ram (
      .clock (clock),
      .we    (mem_req.nxt_we),
      .waddr (mem_req.nxt_waddr),
      .wdata (mem_req.nxt_wdata),
      .raddr (mem_req.node_raddr),
      .rdata (mem_rsp.nxt_rdata)
   );

   dll_ram #(.WIDTH(LINK_BITS), .ADDR_BITS(IDX_BITS)) u_prev_ram (
      .clock (clock),
      .we    (mem_req.prv_we),
      .waddr (mem_req.prv_waddr),
      .wdata (mem_req.prv_wdata),
      .raddr (mem_req.node_raddr),
      .rdata (mem_rsp.prv_rdata)
   );

   dll_ram #(.WIDTH(IDX_BITS), .ADDR_BITS(IDX_BITS)) u_free_ram (
      .clock (clock),
      .we    (mem_req.fre_we),
      .waddr (mem_req.fre_waddr),
      .wdata (mem_req.fre_wdata),
      .raddr (mem_req.fre_raddr),
      .rdata (mem_rsp.fre_rdata)
   );

   // hold the response word until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl_done) begin
         rsp_word_ff <= ctrl_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl_done |-> !(rsp_valid_ff && rsp_stall))
      else $error("response overwritten while stalled");

   a_full_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == STAT_FULL))
         |-> (rsp_word.list_length == LINK_BITS'(CAPACITY)))
      else $error("full status with list not at capacity");

   a_empty_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_word.status == STAT_EMPTY)) |-> (rsp_word.list_length == '0))
      else $error("empty status with nonzero length");

endmodule

// File: bench/bounded_doubly_linked_list_tb.sv
module bounded_doubly_linked_list_tb;
   import dll_pkg::*;

   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int RANDOM_ITEMS = 1180;
   localparam int HOLD_CYCLES  = 600;
   localparam int DRAIN_CYCLES = 300;
   localparam int MAX_GAP      = 40;

   localparam logic [2:0]         ACT_UNUSED_LO = 3'd6;
   localparam logic [2:0]         ACT_UNUSED_HI = 3'd7;
   localparam logic [11:0]        MAX_POS       = 12'hFFF;
   localparam logic signed [31:0] VALUE_MAX     = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] VALUE_MIN     = 32'sh8000_0000;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   typedef struct packed {
      req_word_type word;
      logic         typed;
      rsp_word_type reply;
   } directed_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   logic signed [31:0] list_values[$];
   rsp_word_type       pending_replies[$];
   directed_row_type   directed_rows[$];
   int                 send_idle_pct  = 0;
   int                 recv_stall_pct = 0;
   int                 failures       = 0;
   int                 cycle_count    = 0;
   logic               hold_request   = 1'b0;

   bounded_doubly_linked_list dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   // apply one request to the list and return the word the block should answer with
   function automatic rsp_word_type apply_list_request(req_word_type w);
      rsp_word_type r;
      int           hit;
      r = '0;
      r.status = STAT_OK;
      hit = -1;
      case (w.action)
         ACT_INS_FRONT, ACT_INS_BACK: begin
            if (list_values.size() == CAPACITY) r.status = STAT_FULL;
            else if (w.action == ACT_INS_FRONT) list_values.push_front(w.item_value);
            else list_values.push_back(w.item_value);
         end
         ACT_INS_POS: begin
            // bad position wins over full, full wins over out of range
            if (w.position == 0) r.status = STAT_BAD_POS;
            else if (list_values.size() == CAPACITY) r.status = STAT_FULL;
            else if (int'(w.position) > list_values.size() + 1) r.status = STAT_MISS;
            else list_values.insert(int'(w.position) - 1, w.item_value);
         end
         ACT_DEL_FRONT: begin
            if (list_values.size() == 0) r.status = STAT_EMPTY;
            else r.removed_value = list_values.pop_front();
         end
         ACT_DEL_BACK: begin
            if (list_values.size() == 0) r.status = STAT_EMPTY;
            else r.removed_value = list_values.pop_back();
         end
         ACT_DEL_VALUE: begin
            if (list_values.size() == 0) r.status = STAT_EMPTY;
            else begin
               for (int i = 0; i < list_values.size() && hit < 0; i++)
                  if (list_values[i] == w.item_value) hit = i;
               if (hit < 0) r.status = STAT_MISS;
               else begin
                  r.removed_value = list_values[hit];
                  list_values.delete(hit);
               end
            end
         end
         default: ;
      endcase
      r.list_length = 9'(list_values.size());
      return r;
   endfunction

   function automatic directed_row_type make_row(logic [2:0] act, logic signed [31:0] val,
                                                  logic [11:0] pos, logic typed,
                                                  logic [2:0] st, logic signed [31:0] removed,
                                                  logic [8:0] len);
      directed_row_type row;
      row.word.action        = act;
      row.word.item_value    = val;
      row.word.position      = pos;
      row.typed              = typed;
      row.reply.status       = st;
      row.reply.removed_value = removed;
      row.reply.list_length  = len;
      return row;
   endfunction

   // steer the length toward target; content random, deletes by value mostly hit
   function automatic req_word_type random_request(int target);
      req_word_type w;
      int           len;
      int           roll;
      int           pick;
      len  = list_values.size();
      roll = $urandom_range(99);
      if (roll < 5) w.action = $urandom_range(1) ? ACT_UNUSED_LO : ACT_UNUSED_HI;
      else if ((roll < 70) == (len < target))
         w.action = 3'(ACT_INS_FRONT) + 3'($urandom_range(2));
      else w.action = 3'(ACT_DEL_FRONT) + 3'($urandom_range(2));
      pick = $urandom_range(9);
      if (w.action == ACT_DEL_VALUE && len > 0 && pick < 7)
         w.item_value = list_values[$urandom_range(len - 1)];
      else if (pick < 4) w.item_value = int'($urandom_range(15)) - 8;
      else if (pick < 5) w.item_value = $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
      else w.item_value = $urandom;
      pick = $urandom_range(9);
      if (w.action != ACT_INS_POS) w.position = 12'($urandom);
      else if (pick == 0) w.position = '0;
      else if (pick == 1) w.position = 12'($urandom_range(MAX_POS));
      else w.position = 12'($urandom_range(len + 1, 1));
      return w;
   endfunction

   task automatic set_idle_mode(idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
         IDLE_SEND: begin send_idle_pct = 62; recv_stall_pct = 0;  end
         IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 62; end
         default:   begin send_idle_pct = 26; recv_stall_pct = 26; end
      endcase
   endtask

   // offer one word, wait for it to be taken, then record what should come back
   task automatic issue(req_word_type word, logic typed, rsp_word_type typed_reply);
      rsp_word_type predicted;
      int           gap;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = apply_list_request(word);
      pending_replies.push_back(typed ? typed_reply : predicted);
   endtask

   // response side: check every word taken, stall at random or hold off on request
   initial begin
      rsp_word_type due;
      int           hold_left;
      logic         hold_started;
      hold_left    = 0;
      hold_started = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_replies.size() == 0) begin
               $error("response word with nothing expected: status %0d removed %0d length %0d",
                      rsp_word.status, rsp_word.removed_value, rsp_word.list_length);
               failures++;
            end else begin
               due = pending_replies.pop_front();
               if (rsp_word.status !== due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_word.status);
                  failures++;
               end
               if (rsp_word.removed_value !== due.removed_value) begin
                  $error("removed_value: expected %0d, got %0d",
                         due.removed_value, rsp_word.removed_value);
                  failures++;
               end
               if (rsp_word.list_length !== due.list_length) begin
                  $error("list_length: expected %0d, got %0d",
                         due.list_length, rsp_word.list_length);
                  failures++;
               end
            end
         end
         if (hold_request && !hold_started) begin
            hold_left    = HOLD_CYCLES;
            hold_started = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_stall_pct);
         end
      end
   end

   initial begin
      req_word_type word;
      req_word_type full_probes[$];
      int           target_length;
      int           pick;
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      set_idle_mode(IDLE_NONE);
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      directed_rows = '{
         make_row(ACT_DEL_FRONT, 0, 0, 1'b1, STAT_EMPTY, 0, 0),
         make_row(ACT_DEL_BACK, -1, MAX_POS, 1'b1, STAT_EMPTY, 0, 0),
         make_row(ACT_DEL_VALUE, 5, 0, 1'b1, STAT_EMPTY, 0, 0),
         make_row(ACT_INS_POS, 7, 0, 1'b1, STAT_BAD_POS, 0, 0),
         make_row(ACT_INS_POS, 7, 2, 1'b1, STAT_MISS, 0, 0),
         make_row(ACT_INS_FRONT, VALUE_MAX, 0, 1'b1, STAT_OK, 0, 1),
         make_row(ACT_INS_BACK, VALUE_MIN, MAX_POS, 1'b1, STAT_OK, 0, 2),
         make_row(ACT_INS_POS, -1, 1, 1'b1, STAT_OK, 0, 3),
         make_row(ACT_INS_POS, 0, 4, 1'b1, STAT_OK, 0, 4),
         make_row(ACT_INS_POS, 3, MAX_POS, 1'b1, STAT_MISS, 0, 4),
         make_row(ACT_INS_POS, 32'sh1234_5678, 3, 1'b0, STAT_OK, 0, 0),
         make_row(ACT_UNUSED_LO, -1, MAX_POS, 1'b1, STAT_OK, 0, 5),
         make_row(ACT_UNUSED_HI, VALUE_MIN, 0, 1'b1, STAT_OK, 0, 5),
         make_row(ACT_DEL_VALUE, 99, 0, 1'b1, STAT_MISS, 0, 5),
         make_row(ACT_DEL_VALUE, VALUE_MIN, 0, 1'b1, STAT_OK, VALUE_MIN, 4),
         make_row(ACT_DEL_FRONT, 0, MAX_POS, 1'b0, STAT_OK, 0, 0),
         make_row(ACT_DEL_BACK, 0, 0, 1'b0, STAT_OK, 0, 0),
         make_row(ACT_DEL_VALUE, VALUE_MAX, 0, 1'b0, STAT_OK, 0, 0),
         make_row(ACT_DEL_FRONT, 0, 0, 1'b0, STAT_OK, 0, 0),
         make_row(ACT_DEL_BACK, 0, 0, 1'b1, STAT_EMPTY, 0, 0)
      };
      foreach (directed_rows[i])
         issue(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].reply);

      // fill to capacity, then probe every insert path against the full list
      while (list_values.size() < CAPACITY) begin
         word.action     = 3'(ACT_INS_FRONT) + 3'($urandom_range(2));
         word.item_value = $urandom;
         word.position   = 12'($urandom_range(list_values.size() + 1, 1));
         issue(word, 1'b0, '0);
      end
      full_probes = '{
         '{ACT_INS_FRONT, VALUE_MIN, 12'd0},
         '{ACT_INS_BACK, VALUE_MAX, MAX_POS},
         '{ACT_INS_POS, 32'sd1, 12'd1},
         '{ACT_INS_POS, 32'sd1, 12'd0},
         '{ACT_INS_POS, 32'sd1, MAX_POS},
         '{ACT_DEL_VALUE, list_values[CAPACITY - 1], 12'd0}
      };
      foreach (full_probes[i]) issue(full_probes[i], 1'b0, '0);

      target_length = 0;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 150 == 0) set_idle_mode(idle_mode_type'((k / 150) % 4));
         if (k % 50 == 0) begin
            pick = $urandom_range(2);
            target_length = (pick == 0) ? 0 : (pick == 1) ? CAPACITY
                                                         : int'($urandom_range(CAPACITY));
         end
         // hold the response side off while requests keep coming
         if (k == RANDOM_ITEMS / 2) hold_request = 1'b1;
         issue(random_request(target_length), 1'b0, '0);
      end
      req_valid <= 1'b0;

      while (pending_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
